/* rtl/bog_pkg.sv */
package bog_pkg;

	localparam int VERTEX_W = 8;
	localparam int OP_W = 2;
	localparam int ARB_W = 4;
	localparam int STATUS_W = 2;
	localparam int DEGREE_FACTOR = 4;
	localparam logic [ARB_W-1:0] ARB_RESET = 4'd1;

	typedef enum logic [OP_W-1:0] {
		OP_QUERY  = 2'd0,
		OP_INSERT = 2'd1,
		OP_ERASE  = 2'd2,
		OP_NONE   = 2'd3
	} op_e;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK   = 2'd0,
		ST_CAP  = 2'd1,
		ST_STEP = 2'd2,
		ST_RSVD = 2'd3
	} status_e;

	typedef struct packed {
		logic [OP_W-1:0]     op;
		logic [VERTEX_W-1:0] vertex_u;
		logic [VERTEX_W-1:0] vertex_v;
	} in_t;

	typedef struct packed {
		logic                is_adjacent;
		logic [STATUS_W-1:0] status;
	} out_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_LEN_RD,
		S_LEN_WAIT,
		S_SCAN_RD,
		S_SCAN_CHK,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_INSERT,
		S_POP,
		S_POP_WAIT,
		S_WLEN,
		S_ENT_RD,
		S_ENT_X,
		S_ENT_XLEN,
		S_FIN
	} state_t;

endpackage

/* rtl/bog_ram.sv */
module bog_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/bog_seq.sv */
module bog_seq #(
	parameter int MAX_VERTICES = 256,
	parameter int LIST_CAPACITY = 64,
	parameter int MAX_CASCADE_STEPS = 4096
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [bog_pkg::ARB_W-1:0]       cfg_wdata,
	input  logic                            req_valid,
	output logic                            req_stall,
	input  bog_pkg::in_t                    req_data,
	output logic                            res_valid,
	input  logic                            res_ready,
	output bog_pkg::out_t                   res_data
);

	localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int LW = $clog2(LIST_CAPACITY + 1);
	localparam int SW = $clog2(MAX_VERTICES * LIST_CAPACITY);
	localparam int PW = $clog2(MAX_VERTICES + 1);
	localparam int STW = $clog2(MAX_CASCADE_STEPS + 1);
	localparam int TW = ((LW > bog_pkg::ARB_W + 2) ? LW : bog_pkg::ARB_W + 2) + 1;
	localparam int VW = bog_pkg::VERTEX_W;
	localparam int CW = (AW > VW) ? AW + 1 : VW + 1;

	bog_pkg::state_t st_q, st_nxt;

	logic [bog_pkg::ARB_W-1:0] arb_q;
	logic [AW-1:0]  clr_q;
	logic [AW-1:0]  a_q, w_q, x_q;
	logic [VW-1:0]  b_q;
	logic [LW-1:0]  n_q, i_q;
	logic [PW-1:0]  sp_q;
	logic [STW-1:0] steps_q;
	logic           phase_q, capf_q, stepf_q, adj_q;
	logic [bog_pkg::OP_W-1:0] op_q;

	// memory ports
	logic          st_we, len_we, stk_we;
	logic [SW-1:0] st_waddr, st_raddr;
	logic [VW-1:0] st_wdata, st_rdata;
	logic [AW-1:0] len_waddr, len_raddr, stk_waddr, stk_raddr;
	logic [LW-1:0] len_wdata, len_rdata;
	logic [VW-1:0] stk_wdata, stk_rdata;

	logic          accept, req_ok, end_of_list, x_in_range, x_full, x_hits, n_full, n_hits;
	logic [TW-1:0] trig;
	logic [LW-1:0] i_inc;

	function automatic logic [SW-1:0] saddr(input logic [AW-1:0] vtx, input logic [LW-1:0] idx);
		saddr = SW'(vtx) * SW'(LIST_CAPACITY) + SW'(idx);
	endfunction

	bog_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES * LIST_CAPACITY)) u_store (
		.clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
		.raddr(st_raddr), .rdata(st_rdata)
	);

	bog_ram #(.WIDTH(LW), .DEPTH(MAX_VERTICES)) u_len (
		.clk(clk), .we(len_we), .waddr(len_waddr), .wdata(len_wdata),
		.raddr(len_raddr), .rdata(len_rdata)
	);

	bog_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_stack (
		.clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
		.raddr(stk_raddr), .rdata(stk_rdata)
	);

	assign req_stall = (st_q != bog_pkg::S_IDLE);
	assign accept = req_valid && !req_stall;
	assign req_ok = (CW'(req_data.vertex_u) < CW'(MAX_VERTICES)) &&
		(CW'(req_data.vertex_v) < CW'(MAX_VERTICES));
	assign trig = TW'(arb_q) * TW'(bog_pkg::DEGREE_FACTOR) + TW'(1);
	assign end_of_list = (i_q >= n_q);
	assign i_inc = i_q + LW'(1);
	assign x_in_range = (CW'(st_rdata) < CW'(MAX_VERTICES));
	assign x_full = (CW'(len_rdata) >= CW'(LIST_CAPACITY));
	assign x_hits = ((TW'(len_rdata) + TW'(1)) == trig);
	assign n_full = (CW'(n_q) >= CW'(LIST_CAPACITY));
	assign n_hits = ((TW'(n_q) + TW'(1)) == trig);

	assign res_valid = (st_q == bog_pkg::S_FIN);
	assign res_data.is_adjacent = adj_q;
	assign res_data.status = stepf_q ? bog_pkg::ST_STEP :
		(capf_q ? bog_pkg::ST_CAP : bog_pkg::ST_OK);

	// next state
	always_comb begin
		st_nxt = st_q;
		unique case (st_q)
			bog_pkg::S_CLEAR: begin
				if (clr_q == AW'(MAX_VERTICES - 1)) st_nxt = bog_pkg::S_IDLE;
			end
			bog_pkg::S_IDLE: begin
				if (accept) begin
					if (req_ok && (req_data.op == bog_pkg::OP_QUERY ||
						req_data.op == bog_pkg::OP_INSERT ||
						req_data.op == bog_pkg::OP_ERASE)) begin
						st_nxt = bog_pkg::S_LEN_RD;
					end else begin
						st_nxt = bog_pkg::S_FIN;
					end
				end
			end
			bog_pkg::S_LEN_RD: st_nxt = bog_pkg::S_LEN_WAIT;
			bog_pkg::S_LEN_WAIT: begin
				st_nxt = (op_q == bog_pkg::OP_INSERT) ? bog_pkg::S_INSERT : bog_pkg::S_SCAN_RD;
			end
			bog_pkg::S_SCAN_RD: begin
				if (!end_of_list) st_nxt = bog_pkg::S_SCAN_CHK;
				else if (!phase_q) st_nxt = bog_pkg::S_LEN_RD;
				else st_nxt = bog_pkg::S_FIN;
			end
			bog_pkg::S_SCAN_CHK: begin
				if (st_rdata == b_q) begin
					st_nxt = (op_q == bog_pkg::OP_QUERY) ? bog_pkg::S_FIN : bog_pkg::S_SHIFT_RD;
				end else begin
					st_nxt = bog_pkg::S_SCAN_RD;
				end
			end
			bog_pkg::S_SHIFT_RD: begin
				st_nxt = (i_inc >= n_q) ? bog_pkg::S_FIN : bog_pkg::S_SHIFT_WR;
			end
			bog_pkg::S_SHIFT_WR: st_nxt = bog_pkg::S_SHIFT_RD;
			bog_pkg::S_INSERT: begin
				st_nxt = (!n_full && n_hits) ? bog_pkg::S_POP : bog_pkg::S_FIN;
			end
			bog_pkg::S_POP: begin
				if (sp_q == '0 || steps_q >= STW'(MAX_CASCADE_STEPS)) begin
					st_nxt = bog_pkg::S_FIN;
				end else begin
					st_nxt = bog_pkg::S_POP_WAIT;
				end
			end
			bog_pkg::S_POP_WAIT: st_nxt = bog_pkg::S_WLEN;
			bog_pkg::S_WLEN: st_nxt = bog_pkg::S_ENT_RD;
			bog_pkg::S_ENT_RD: st_nxt = end_of_list ? bog_pkg::S_POP : bog_pkg::S_ENT_X;
			bog_pkg::S_ENT_X: st_nxt = x_in_range ? bog_pkg::S_ENT_XLEN : bog_pkg::S_ENT_RD;
			bog_pkg::S_ENT_XLEN: st_nxt = bog_pkg::S_ENT_RD;
			bog_pkg::S_FIN: begin
				if (res_ready) st_nxt = bog_pkg::S_IDLE;
			end
			default: st_nxt = bog_pkg::S_IDLE;
		endcase
	end

	// memory port control
	always_comb begin
		st_we = 1'b0;
		st_waddr = saddr(a_q, n_q);
		st_wdata = b_q;
		st_raddr = saddr(a_q, i_q);
		len_we = 1'b0;
		len_waddr = a_q;
		len_wdata = n_q + LW'(1);
		len_raddr = a_q;
		stk_we = 1'b0;
		stk_waddr = AW'(sp_q);
		stk_wdata = VW'(x_q);
		stk_raddr = AW'(sp_q - PW'(1));
		unique case (st_q)
			bog_pkg::S_CLEAR: begin
				len_we = 1'b1;
				len_waddr = clr_q;
				len_wdata = '0;
			end
			bog_pkg::S_SHIFT_RD: begin
				st_raddr = saddr(a_q, i_inc);
				len_we = (i_inc >= n_q);
				len_wdata = n_q - LW'(1);
			end
			bog_pkg::S_SHIFT_WR: begin
				st_we = 1'b1;
				st_waddr = saddr(a_q, i_q);
				st_wdata = st_rdata;
			end
			bog_pkg::S_INSERT: begin
				st_we = !n_full;
				len_we = !n_full;
				stk_we = !n_full && n_hits;
				stk_waddr = '0;
				stk_wdata = VW'(a_q);
			end
			bog_pkg::S_POP_WAIT: len_raddr = AW'(stk_rdata);
			bog_pkg::S_WLEN: begin
				len_we = 1'b1;
				len_waddr = w_q;
				len_wdata = '0;
			end
			bog_pkg::S_ENT_RD: st_raddr = saddr(w_q, i_q);
			bog_pkg::S_ENT_X: len_raddr = AW'(st_rdata);
			bog_pkg::S_ENT_XLEN: begin
				st_we = !x_full;
				st_waddr = saddr(x_q, len_rdata);
				st_wdata = VW'(w_q);
				len_we = !x_full;
				len_waddr = x_q;
				len_wdata = len_rdata + LW'(1);
				stk_we = !x_full && x_hits && (CW'(sp_q) < CW'(MAX_VERTICES));
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= bog_pkg::S_CLEAR;
		end else begin
			st_q <= st_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arb_q <= bog_pkg::ARB_RESET;
			clr_q <= '0;
			sp_q <= '0;
			steps_q <= '0;
			phase_q <= 1'b0;
			capf_q <= 1'b0;
			stepf_q <= 1'b0;
			adj_q <= 1'b0;
			op_q <= bog_pkg::OP_NONE;
		end else begin
			if (cfg_we) arb_q <= cfg_wdata;
			case (st_q)
				bog_pkg::S_CLEAR: clr_q <= clr_q + AW'(1);
				bog_pkg::S_IDLE: begin
					if (accept) begin
						op_q <= req_data.op;
						phase_q <= 1'b0;
						capf_q <= 1'b0;
						stepf_q <= 1'b0;
						adj_q <= 1'b0;
						sp_q <= '0;
						steps_q <= '0;
					end
				end
				bog_pkg::S_SCAN_RD: if (end_of_list) phase_q <= 1'b1;
				bog_pkg::S_SCAN_CHK: begin
					if (st_rdata == b_q && op_q == bog_pkg::OP_QUERY) adj_q <= 1'b1;
				end
				bog_pkg::S_INSERT: begin
					if (n_full) capf_q <= 1'b1;
					else if (n_hits) sp_q <= PW'(1);
				end
				bog_pkg::S_POP: begin
					if (sp_q != '0) begin
						if (steps_q >= STW'(MAX_CASCADE_STEPS)) begin
							stepf_q <= 1'b1;
							sp_q <= '0;
						end else begin
							steps_q <= steps_q + STW'(1);
							sp_q <= sp_q - PW'(1);
						end
					end
				end
				bog_pkg::S_ENT_XLEN: begin
					if (x_full) begin
						capf_q <= 1'b1;
					end else if (x_hits) begin
						if (CW'(sp_q) < CW'(MAX_VERTICES)) sp_q <= sp_q + PW'(1);
						else stepf_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (st_q)
			bog_pkg::S_IDLE: begin
				a_q <= AW'(req_data.vertex_u);
				b_q <= req_data.vertex_v;
			end
			bog_pkg::S_LEN_WAIT: begin
				n_q <= len_rdata;
				i_q <= '0;
			end
			bog_pkg::S_SCAN_RD: begin
				if (end_of_list) begin
					// second pass looks for u in v's list
					a_q <= AW'(b_q);
					b_q <= VW'(a_q);
				end
			end
			bog_pkg::S_SCAN_CHK: if (st_rdata != b_q) i_q <= i_inc;
			bog_pkg::S_SHIFT_WR: i_q <= i_inc;
			bog_pkg::S_POP_WAIT: w_q <= AW'(stk_rdata);
			bog_pkg::S_WLEN: begin
				n_q <= len_rdata;
				i_q <= '0;
			end
			bog_pkg::S_ENT_X: begin
				x_q <= AW'(st_rdata);
				if (!x_in_range) i_q <= i_inc;
			end
			bog_pkg::S_ENT_XLEN: i_q <= i_inc;
			default: ;
		endcase
	end

endmodule

/* rtl/bounded_outdegree_graph_orientation_core.sv */
// oriented graph store with bounded out-degree, one out-list per vertex
// in channel: in_valid/in_stall carry one request word (query, insert or erase)
// out channel: out_valid/out_stall return exactly one result word per request
// cfg_we/cfg_wdata write the arboricity; the out-degree limit is four times it
// a query or erase reads the length of u's list then scans it, and if no match is
// found does the same for v's list; an erase shifts each entry after the match down
// an insert appends v to u's list; a reset cascade pops each vertex, clears its
// list and moves each entry to its target's list; every list entry goes through the one list memory
// a request is taken only when the previous one has finished, so the core never
// holds more than one request at a time
// after reset the length memory is cleared, one vertex per cycle, while in_stall
// stays high; arboricity resets to 1
// a finished word sits in the output register while the next request is taken;
// if out_stall holds it there, the next result waits before the sequencer goes idle
module bounded_outdegree_graph_orientation_core #(
	parameter int MAX_VERTICES = 256,
	parameter int LIST_CAPACITY = 64,
	parameter int MAX_CASCADE_STEPS = 4096
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [bog_pkg::ARB_W-1:0] cfg_wdata,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  bog_pkg::in_t              in_data,
	output logic                      out_valid,
	input  logic                      out_stall,
	output bog_pkg::out_t             out_data
);

	logic          res_valid, res_ready, out_valid_q;
	bog_pkg::out_t res_data, out_data_q;

	bog_seq #(
		.MAX_VERTICES(MAX_VERTICES),
		.LIST_CAPACITY(LIST_CAPACITY),
		.MAX_CASCADE_STEPS(MAX_CASCADE_STEPS)
	) u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.req_valid(in_valid),
		.req_stall(in_stall),
		.req_data(in_data),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res_data(res_data)
	);

	assign res_ready = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) out_data_q <= res_data;
	end

	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

endmodule

/* verif/tb_top.sv */
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NV = 256;
	localparam int CAP = 64;
	localparam int MAX_STEPS = 4096;
	localparam int WATCH_LIMIT = 4000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [bog_pkg::ARB_W-1:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	bog_pkg::in_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	bog_pkg::out_t out_data;

	bounded_outdegree_graph_orientation_core uut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	always #4 clk = ~clk;

	// graph mirror
	logic [7:0] adj_list [NV][CAP];
	int adj_len [NV];
	logic [bog_pkg::ARB_W-1:0] arb_bound = bog_pkg::ARB_RESET;
	bog_pkg::out_t expected_words[$];

	int mismatches = 0;
	int idle_pct = 0;
	int stall_pct = 0;
	int quiet_cycles = 0;

	function automatic bit has_edge(int a, int b);
		for (int i = 0; i < adj_len[a]; i++)
			if (adj_list[a][i] == b[7:0]) return 1'b1;
		return 1'b0;
	endfunction

	function automatic bit push_entry(int a, int b);
		if (adj_len[a] >= CAP) return 1'b0;
		adj_list[a][adj_len[a]] = b[7:0];
		adj_len[a]++;
		return 1'b1;
	endfunction

	function automatic bit drop_entry(int a, int b);
		for (int i = 0; i < adj_len[a]; i++)
			if (adj_list[a][i] == b[7:0]) begin
				for (int k = i; k + 1 < adj_len[a]; k++) adj_list[a][k] = adj_list[a][k+1];
				adj_len[a]--;
				return 1'b1;
			end
		return 1'b0;
	endfunction

	function automatic logic [1:0] orient_insert(int u, int v);
		int trig, steps, w, n, x, sp;
		bit cap_f, step_f;
		int stk[NV];
		logic [7:0] snap[CAP];
		trig = 4 * int'(arb_bound) + 1;
		cap_f = 0;
		step_f = 0;
		steps = 0;
		sp = 0;
		if (!push_entry(u, v)) return bog_pkg::ST_CAP;
		if (adj_len[u] != trig) return bog_pkg::ST_OK;
		stk[sp] = u;
		sp++;
		while (sp > 0) begin
			if (steps >= MAX_STEPS) begin
				step_f = 1;
				sp = 0;
				break;
			end
			steps++;
			sp--;
			w = stk[sp];
			n = adj_len[w];
			for (int i = 0; i < n; i++) snap[i] = adj_list[w][i];
			adj_len[w] = 0;
			for (int i = 0; i < n; i++) begin
				x = snap[i];
				if (!push_entry(x, w)) begin
					cap_f = 1;
					continue;
				end
				if (adj_len[x] == trig) begin
					if (sp < NV) begin
						stk[sp] = x;
						sp++;
					end else begin
						step_f = 1;
					end
				end
			end
		end
		if (step_f) return bog_pkg::ST_STEP;
		return cap_f ? bog_pkg::ST_CAP : bog_pkg::ST_OK;
	endfunction

	function automatic bog_pkg::out_t predict_word(bog_pkg::in_t w);
		bog_pkg::out_t r;
		r = '0;
		case (w.op)
			bog_pkg::OP_QUERY: r.is_adjacent = has_edge(w.vertex_u, w.vertex_v) ||
				has_edge(w.vertex_v, w.vertex_u);
			bog_pkg::OP_INSERT: r.status = orient_insert(w.vertex_u, w.vertex_v);
			bog_pkg::OP_ERASE: if (!drop_entry(w.vertex_u, w.vertex_v))
				void'(drop_entry(w.vertex_v, w.vertex_u));
			default: ;
		endcase
		return r;
	endfunction

	// in_valid stays high after a word until the next word or drain decides
	task automatic send_word(logic [1:0] op, logic [7:0] u, logic [7:0] v);
		bog_pkg::in_t w;
		w.op = op;
		w.vertex_u = u;
		w.vertex_v = v;
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= w;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		expected_words.insert(expected_words.size(), predict_word(w));
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (expected_words.size() > 0) @(posedge clk);
		repeat (600) @(posedge clk);
	endtask

	task automatic set_arboricity(logic [3:0] a);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= a;
		@(posedge clk);
		cfg_we <= 1'b0;
		arb_bound = a;
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_words.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected word %h", out_data);
			end else begin
				bog_pkg::out_t e;
				e = expected_words.pop_front();
				if (e.is_adjacent !== out_data.is_adjacent || e.status !== out_data.status) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp adj %b st %0d, got adj %b st %0d",
							e.is_adjacent, e.status, out_data.is_adjacent, out_data.status);
				end
			end
		end
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCH_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic test_directed();
		send_word(bog_pkg::OP_QUERY, 8'd0, 8'd255);
		send_word(bog_pkg::OP_INSERT, 8'd0, 8'd255);
		send_word(bog_pkg::OP_QUERY, 8'd255, 8'd0);
		send_word(bog_pkg::OP_QUERY, 8'd0, 8'd255);
		send_word(bog_pkg::OP_NONE, 8'd0, 8'd255);
		send_word(bog_pkg::OP_INSERT, 8'd7, 8'd7);
		send_word(bog_pkg::OP_ERASE, 8'd9, 8'd9);
		send_word(bog_pkg::OP_ERASE, 8'd255, 8'd0);
		send_word(bog_pkg::OP_QUERY, 8'd0, 8'd255);
		// fill vertex 1 to trigger a cascade at limit 4
		for (int i = 2; i < 7; i++) send_word(bog_pkg::OP_INSERT, 8'd1, i[7:0]);
		send_word(bog_pkg::OP_QUERY, 8'd2, 8'd1);
		send_word(bog_pkg::OP_ERASE, 8'd1, 8'd3);
		send_word(bog_pkg::OP_QUERY, 8'd3, 8'd1);
		send_word(bog_pkg::OP_NONE, 8'hff, 8'hff);
	endtask

	// limit zero: an insert into an empty list starts a cascade, incl. self-loops
	task automatic test_zero_limit();
		set_arboricity(4'd0);
		send_word(bog_pkg::OP_INSERT, 8'd20, 8'd20);
		send_word(bog_pkg::OP_INSERT, 8'd20, 8'd21);
		send_word(bog_pkg::OP_INSERT, 8'd21, 8'd20);
		send_word(bog_pkg::OP_QUERY, 8'd20, 8'd21);
		for (int i = 0; i < 40; i++)
			send_word(2'($urandom_range(2)), 8'($urandom_range(15)), 8'($urandom_range(15)));
	endtask

	// trigger below capacity: the list cascades before it can overflow
	task automatic test_overflow();
		set_arboricity(4'd15);
		for (int i = 0; i < 70; i++) send_word(bog_pkg::OP_INSERT, 8'd30, i[7:0]);
		send_word(bog_pkg::OP_QUERY, 8'd30, 8'd69);
		send_word(bog_pkg::OP_ERASE, 8'd30, 8'd5);
		send_word(bog_pkg::OP_INSERT, 8'd30, 8'hAA);
	endtask

	task automatic random_phase(int items, int ip, int sp, logic [3:0] arb, int span);
		logic [1:0] op;
		set_arboricity(arb);
		idle_pct = ip;
		stall_pct = sp;
		for (int i = 0; i < items; i++) begin
			op = ($urandom_range(99) < 3) ? bog_pkg::OP_NONE : 2'($urandom_range(2));
			if ($urandom_range(99) < 5)
				send_word(op, 8'($urandom), 8'($urandom));
			else
				send_word(op, 8'($urandom_range(span - 1)), 8'($urandom_range(span - 1)));
		end
	endtask

	task automatic test_random();
		random_phase(300, 0, 0, 4'd1, 12);
		random_phase(300, 76, 0, 4'd2, 24);
		random_phase(300, 0, 76, 4'd0, 8);
		drain();
		random_phase(300, 18, 18, 4'd15, 256);
		random_phase(300, 0, 0, 4'd3, 20);
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		for (int i = 0; i < NV; i++) adj_len[i] = 0;
		test_directed();
		test_zero_limit();
		test_overflow();
		test_random();
		drain();
		if (mismatches == 0 && expected_words.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
